/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RGB minimum filter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

/* src/rmf_pkg.sv */
// ---------------------------------------------------------------------------
// rmf_pkg
// Constants, types and helpers shared by the RGB minimum filter modules.
// ---------------------------------------------------------------------------
`default_nettype none

package rmf_pkg;

   localparam int MAX_WIDTH = 2048;
   localparam int RADIUS    = 3;
   localparam int SPAN      = 2 * RADIUS + 1;

   localparam int CHAN_W = 8;
   localparam int DIM_W  = 12;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int SLOT_W = $clog2(SPAN);
   localparam int W_W    = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
   localparam int PEND_W = $clog2(RADIUS * MAX_WIDTH + RADIUS + 2);

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic [COL_W-1:0]  col;
      pixel_type         data;
   } store_wr_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] col_a;
      logic [COL_W-1:0] col_b;
   } store_rd_type;

   function automatic pixel_type pix_min(input pixel_type a, input pixel_type b);
      pixel_type m;
      m.red   = (a.red   < b.red)   ? a.red   : b.red;
      m.green = (a.green < b.green) ? a.green : b.green;
      m.blue  = (a.blue  < b.blue)  ? a.blue  : b.blue;
      return m;
   endfunction

endpackage

`default_nettype wire

/* src/rgb_min_filter_window_unit.sv */
// ---------------------------------------------------------------------------
// rgb_min_filter_window_unit
// Streaming per-channel 7x7 minimum filter (erosion) over RGB raster frames.
// ---------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  req     | in        | req_valid/req_stall  | op, red_in, green_in, blue_in
//  rsp     | out       | rsp_valid/rsp_stall  | red_out, green_out, blue_out,
//          |           |                      | last_of_frame
//  csr     | in        | csr_write_en         | csr_index, csr_wdata
//
// One request per clock is taken while req_stall is low; a result passes the
// line memory read, two compare stages and the output register.
// Column minima are formed as pixels arrive; a row of seven of them is kept.
// The line memory is not cleared after reset; counters and flags are.
// A skid register behind the output register keeps req_stall registered, so
// a stalled result holds the pipeline from the cycle after the skid fills.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rgb_min_filter_window_unit import rmf_pkg::*; (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire                  req_op,
   input  wire  [CHAN_W-1:0]    req_red_in,
   input  wire  [CHAN_W-1:0]    req_green_in,
   input  wire  [CHAN_W-1:0]    req_blue_in,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic [CHAN_W-1:0]    rsp_red_out,
   output logic [CHAN_W-1:0]    rsp_green_out,
   output logic [CHAN_W-1:0]    rsp_blue_out,
   output logic                 rsp_last_of_frame,
   input  wire                  csr_write_en,
   input  wire  [CSR_IDX_W-1:0] csr_index,
   input  wire  [DIM_W-1:0]     csr_wdata
);

   typedef struct packed {
      logic              fwd;
      logic              interior;
      logic              last;
      logic [SLOT_W-1:0] in_slot;
      logic [SLOT_W-1:0] out_slot;
      pixel_type         pix;
   } stage1_type;

   typedef struct packed {
      logic      interior;
      logic      last;
      pixel_type centre;
   } stage2_type;

   // Configuration and raster state
   logic [DIM_W-1:0]  frame_width_ff, frame_height_ff;
   logic [COL_W-1:0]  in_column_ff, in_column_in;
   logic [DIM_W-1:0]  in_row_ff, in_row_in;
   logic [COL_W-1:0]  out_column_ff, out_column_in;
   logic [DIM_W-1:0]  out_row_ff, out_row_in;
   logic [SLOT_W-1:0] in_slot_ff, in_slot_in;
   logic [SLOT_W-1:0] out_slot_ff, out_slot_in;
   logic [PEND_W-1:0] pending_ff, pending_in;

   logic [W_W-1:0]    eff_w;
   logic [DIM_W-1:0]  eff_h;
   logic [PEND_W-1:0] lag;
   logic [PEND_W-1:0] pend_after;
   logic              is_pixel, emit, advance, accept;
   logic              in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap;
   pixel_type         req_pix;
   stage1_type        s1_in;

   // Pipeline
   logic       s1_valid_ff, s1_push_ff, s2_valid_ff;
   stage1_type s1_ff;
   stage2_type s2_ff, s2_in;
   pixel_type  col_min, win_min;
   pixel_type  hist_ff [SPAN];

   // Output register and skid
   logic      rsp_valid_ff, skid_full_ff;
   logic      rsp_valid_in, skid_full_in;
   pixel_type out_pix_ff, skid_pix_ff;
   logic      out_last_ff, skid_last_ff;
   logic      take, new_item, load_out, load_skid;

   store_wr_type st_wr;
   store_rd_type st_rd;
   pixel_type    col_data [SPAN];
   pixel_type    ctr_data [SPAN];

   assign advance   = !skid_full_ff;
   assign req_stall = skid_full_ff;
   assign accept    = req_valid && advance;
   assign is_pixel  = (req_op == OP_PIXEL);
   assign req_pix   = '{red: req_red_in, green: req_green_in, blue: req_blue_in};

   // ---------------- request stage: counters and emit decision ----------------
   always_comb begin
      if (frame_width_ff == '0) begin
         eff_w = W_W'(1);
      end else if (W_W'(frame_width_ff) > W_W'(MAX_WIDTH)) begin
         eff_w = W_W'(MAX_WIDTH);
      end else begin
         eff_w = W_W'(frame_width_ff);
      end
      eff_h = (frame_height_ff == '0) ? DIM_W'(1) : frame_height_ff;
      lag   = PEND_W'(RADIUS) * PEND_W'(eff_w) + PEND_W'(RADIUS);

      in_col_wrap = (W_W'(in_column_ff) + W_W'(1)) >= eff_w;
      in_row_wrap = ((DIM_W + 1)'(in_row_ff) + (DIM_W + 1)'(1)) >= (DIM_W + 1)'(eff_h);
      out_col_wrap = (W_W'(out_column_ff) + W_W'(1)) >= eff_w;
      out_row_wrap = ((DIM_W + 1)'(out_row_ff) + (DIM_W + 1)'(1)) >= (DIM_W + 1)'(eff_h);

      in_column_in = in_column_ff;
      in_row_in    = in_row_ff;
      in_slot_in   = in_slot_ff;
      if (is_pixel) begin
         if (in_col_wrap) begin
            in_column_in = '0;
            in_slot_in   = (in_slot_ff == SLOT_W'(SPAN - 1)) ? '0 : in_slot_ff + SLOT_W'(1);
            in_row_in    = in_row_wrap ? '0 : in_row_ff + DIM_W'(1);
         end else begin
            in_column_in = in_column_ff + COL_W'(1);
         end
      end

      if (is_pixel) begin
         pend_after = (pending_ff <= lag) ? pending_ff + PEND_W'(1) : pending_ff;
         emit       = pend_after > lag;
      end else begin
         pend_after = pending_ff;
         // A drain only releases the tail once the whole frame has arrived.
         emit = (pending_ff != '0) && (in_row_ff == '0) && (in_column_ff == '0);
      end
      pending_in = emit ? pend_after - PEND_W'(1) : pend_after;

      out_column_in = out_column_ff;
      out_row_in    = out_row_ff;
      out_slot_in   = out_slot_ff;
      if (emit) begin
         if (out_col_wrap) begin
            out_column_in = '0;
            out_slot_in   = (out_slot_ff == SLOT_W'(SPAN - 1)) ? '0 : out_slot_ff + SLOT_W'(1);
            out_row_in    = out_row_wrap ? '0 : out_row_ff + DIM_W'(1);
         end else begin
            out_column_in = out_column_ff + COL_W'(1);
         end
      end

      s1_in.fwd      = is_pixel && (in_slot_ff == out_slot_ff) && (in_column_ff == out_column_ff);
      s1_in.interior = (out_row_ff >= DIM_W'(RADIUS))
                    && (((DIM_W + 1)'(out_row_ff) + (DIM_W + 1)'(RADIUS)) < (DIM_W + 1)'(eff_h))
                    && (out_column_ff >= COL_W'(RADIUS))
                    && (((W_W + 1)'(out_column_ff) + (W_W + 1)'(RADIUS)) < (W_W + 1)'(eff_w));
      s1_in.last     = out_row_wrap && out_col_wrap;
      s1_in.in_slot  = in_slot_ff;
      s1_in.out_slot = out_slot_ff;
      s1_in.pix      = req_pix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
         in_column_ff    <= '0;
         in_row_ff       <= '0;
         out_column_ff   <= '0;
         out_row_ff      <= '0;
         in_slot_ff      <= '0;
         out_slot_ff     <= '0;
         pending_ff      <= '0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               REG_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
               REG_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            in_column_ff  <= in_column_in;
            in_row_ff     <= in_row_in;
            out_column_ff <= out_column_in;
            out_row_ff    <= out_row_in;
            in_slot_ff    <= in_slot_in;
            out_slot_ff   <= out_slot_in;
            pending_ff    <= pending_in;
         end
      end
   end

   // ---------------- line memory ----------------
   assign st_wr.en    = accept && is_pixel;
   assign st_wr.slot  = in_slot_ff;
   assign st_wr.col   = in_column_ff;
   assign st_wr.data  = req_pix;
   assign st_rd.en    = accept;
   assign st_rd.col_a = in_column_ff;
   assign st_rd.col_b = out_column_ff;

   rmf_line_store u_line_store (
      .clock    (clock),
      .wr       (st_wr),
      .rd       (st_rd),
      .col_data (col_data),
      .ctr_data (ctr_data)
   );

   // ---------------- stage 1: column minimum and centre pick ----------------
   always_comb begin
      // The bank being overwritten holds the oldest row; the new pixel replaces it.
      col_min = s1_ff.pix;
      for (int b = 0; b < SPAN; b++) begin
         if (SLOT_W'(b) != s1_ff.in_slot) begin
            col_min = pix_min(col_min, col_data[b]);
         end
      end
      s2_in.interior = s1_ff.interior;
      s2_in.last     = s1_ff.last;
      s2_in.centre   = s1_ff.fwd ? s1_ff.pix : ctr_data[s1_ff.out_slot];
   end

   // ---------------- stage 2: minimum across the column row ----------------
   always_comb begin
      win_min = hist_ff[0];
      for (int i = 1; i < SPAN; i++) begin
         win_min = pix_min(win_min, hist_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_push_ff  <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept && emit;
         s1_push_ff  <= accept && is_pixel;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (advance) begin
         s2_ff <= s2_in;
      end
      if (advance && s1_push_ff) begin
         hist_ff[0] <= col_min;
         for (int i = 1; i < SPAN; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
      end
   end

   // ---------------- output register and skid ----------------
   assign take      = rsp_valid_ff && !rsp_stall;
   assign new_item  = advance && s2_valid_ff;
   assign load_out  = skid_full_ff ? take : (new_item && (!rsp_valid_ff || take));
   assign load_skid = !skid_full_ff && new_item && rsp_valid_ff && !take;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      skid_full_in = skid_full_ff;
      if (skid_full_ff) begin
         if (take) begin
            skid_full_in = 1'b0;
         end
      end else if (new_item) begin
         rsp_valid_in = 1'b1;
         if (rsp_valid_ff && !take) begin
            skid_full_in = 1'b1;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         if (skid_full_ff) begin
            out_pix_ff  <= skid_pix_ff;
            out_last_ff <= skid_last_ff;
         end else begin
            out_pix_ff  <= s2_ff.interior ? win_min : s2_ff.centre;
            out_last_ff <= s2_ff.last;
         end
      end
      if (load_skid) begin
         skid_pix_ff  <= s2_ff.interior ? win_min : s2_ff.centre;
         skid_last_ff <= s2_ff.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_red_out       = out_pix_ff.red;
   assign rsp_green_out     = out_pix_ff.green;
   assign rsp_blue_out      = out_pix_ff.blue;
   assign rsp_last_of_frame = out_last_ff;

   // ---------------- assertions ----------------
   `ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_full_ff, rsp_valid_ff)
   `ASSERT_NEXT(a_skid_drains, clock, reset, skid_full_ff && !rsp_stall, !skid_full_ff && rsp_valid_ff)
   `ASSERT_NEXT(a_pipe_frozen, clock, reset, skid_full_ff, $stable(s2_valid_ff) && $stable(s1_valid_ff))
   `ASSERT_IMPLIES(a_slot_range, clock, reset, 1'b1, (in_slot_ff < SLOT_W'(SPAN)) && (out_slot_ff < SLOT_W'(SPAN)))

endmodule

`default_nettype wire

/* src/rmf_line_store.sv */
// ---------------------------------------------------------------------------
// rmf_line_store
// Ring of line memories, one bank per window row, one write and two reads.
// ---------------------------------------------------------------------------
`default_nettype none

module rmf_line_store import rmf_pkg::*; (
   input  wire          clock,
   input  store_wr_type wr,
   input  store_rd_type rd,
   output pixel_type    col_data [SPAN],
   output pixel_type    ctr_data [SPAN]
);

   // Every bank is read at both addresses; the caller picks what it needs.
   for (genvar b = 0; b < SPAN; b++) begin : g_bank
      pixel_type bank_mem [MAX_WIDTH];
      pixel_type rd_a_ff;
      pixel_type rd_b_ff;

      always_ff @(posedge clock) begin
         if (wr.en && (wr.slot == SLOT_W'(b))) begin
            bank_mem[wr.col] <= wr.data;
         end
         if (rd.en) begin
            rd_a_ff <= bank_mem[rd.col_a];
            rd_b_ff <= bank_mem[rd.col_b];
         end
      end

      assign col_data[b] = rd_a_ff;
      assign ctr_data[b] = rd_b_ff;
   end

endmodule

`default_nettype wire
